// File: hdl/fec_block_window_tracker_macros.svh
// Assertion macros shared by the tracker RTL.
`ifndef FEC_BLOCK_WINDOW_TRACKER_MACROS_SVH
`define FEC_BLOCK_WINDOW_TRACKER_MACROS_SVH
`ifndef ASSERT_OFF
`define FBWT_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
`define FBWT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define FBWT_ASSERT_IMPLY(label, ante, cons)
`define FBWT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: hdl/fbwt_pkg.sv
// Package with widths, codes and defaults of the FEC block window tracker.
package fbwt_pkg;
	localparam int RING_DEPTH_DEF = 8;
	localparam int MAX_BLOCK_DEF  = 64;
	localparam int SEQ_W     = 32;
	localparam int TYPE_W    = 4;
	localparam int ACT_W     = 3;
	localparam int SLOT_W    = 3;
	localparam int OFF_W     = 6;
	localparam int READY_W   = 4;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 1;
	localparam int COUNT_W   = 16;

	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LEN = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_COUNT = 1'd1;
	localparam logic [CFG_W-1:0] BLOCK_LEN_RESET = 7'd8;
	localparam logic [CFG_W-1:0] SRC_COUNT_RESET = 7'd6;

	localparam logic [TYPE_W-1:0] CANDIDATE_TYPE = 4'd2;

	localparam logic [ACT_W-1:0] ACT_NEW   = 3'd0;
	localparam logic [ACT_W-1:0] ACT_PLACE = 3'd1;
	localparam logic [ACT_W-1:0] ACT_OLD   = 3'd2;
	localparam logic [ACT_W-1:0] ACT_RESET = 3'd3;
	localparam logic [ACT_W-1:0] ACT_OUT   = 3'd4;
endpackage

// File: hdl/fec_block_window_tracker.sv
// Top level of the FEC block window tracker: ring memories, divider, placement and scan.
// Usage: a packet transaction is offered with start high and taken at a clock edge where
// busy is low; seq_num and type_nibble are sampled at that edge. The block then works
// alone and presents one result for exactly one cycle with done high: action, ring_slot,
// block_offset and ready_window. The receiver cannot stall, so nothing waits on it.
// Steps per packet: the accept, the bit-serial remainder and a decision; then, as needed,
// a search of the ring for the window of an older block plus a read-modify-write of its
// record when found, or a clear of the bases on a ring reset; then a scan over the record
// memory and the result.
// Only one packet is in flight; the remainder loop and the single memory read port
// set that figure. Configuration writes (cfg_we, cfg_idx, cfg_data) take effect at once;
// the user makes them only while busy is low, which the block itself does not enforce.
// After reset the block clears both memories with busy high.
`include "fec_block_window_tracker_macros.svh"
module fec_block_window_tracker
	import fbwt_pkg::*;
#(
	parameter int RING_DEPTH = RING_DEPTH_DEF,
	parameter int MAX_BLOCK  = MAX_BLOCK_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [SEQ_W-1:0]   seq_num,
	input  logic [TYPE_W-1:0]  type_nibble,
	input  logic               cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]   cfg_data,
	output logic               done,
	output logic [ACT_W-1:0]   action,
	output logic [SLOT_W-1:0]  ring_slot,
	output logic [OFF_W-1:0]   block_offset,
	output logic [READY_W-1:0] ready_window
);
	localparam int IW = $clog2(RING_DEPTH);
	localparam int NW = $clog2(RING_DEPTH + 1);

	typedef struct packed {
		logic [MAX_BLOCK-1:0] recv;
		logic [MAX_BLOCK-1:0] mark;
		logic [COUNT_W-1:0]   count;
	} rec_t;

	localparam logic [3:0] S_INIT  = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_DIV   = 4'd2;
	localparam logic [3:0] S_DEC   = 4'd3;
	localparam logic [3:0] S_BACK  = 4'd4;
	localparam logic [3:0] S_PLACE = 4'd5;
	localparam logic [3:0] S_CLR   = 4'd6;
	localparam logic [3:0] S_SCAN  = 4'd7;
	localparam logic [3:0] S_DONE  = 4'd8;

	logic [3:0]          state_q;
	logic [CFG_W-1:0]    block_len_q, src_count_q;
	logic [IW-1:0]       ring_start_q, clr_idx_q, k_q, slot_q;
	logic [SEQ_W-1:0]    seq_q, seq_sh_q, base_end_q, base_start_q, diff_q;
	logic [TYPE_W-1:0]   type_q;
	logic [CFG_W-1:0]    rem_q;
	logic [4:0]          div_cnt_q;
	logic [ACT_W-1:0]    action_q;
	logic [NW-1:0]       left_q, num_s1, found_q, second_q;
	logic                v_s1, done_q;

	logic [SEQ_W-1:0]    base_mem [RING_DEPTH];
	rec_t                rec_mem [RING_DEPTH];
	logic [SEQ_W-1:0]    base_rd_q;
	rec_t                rec_rd_q;

	logic                base_we, rec_we;
	logic [IW-1:0]       base_waddr, base_raddr, rec_waddr, rec_raddr;
	logic [SEQ_W-1:0]    base_wdata;
	rec_t                rec_wdata;

	logic [CFG_W-1:0]    bl, lim;
	logic [MAX_BLOCK-1:0] src_mask, off_bit;
	logic [CFG_W:0]      div_t;
	logic [SEQ_W-1:0]    base;
	logic [IW-1:0]       end_idx, start_nxt, p_idx, scan_addr;
	logic [IW:0]         p_sum, scan_sum;
	logic [NW-1:0]       scan_i;
	logic                is_cand, hit;
	logic [SEQ_W:0]      far_sum;
	rec_t                placed;
	logic [IW+SLOT_W-1:0] slot_ext;
	logic [NW+READY_W-1:0] ready_ext;
	logic                drop_act;

	always_comb begin
		if (block_len_q == '0) begin
			bl = 7'd1;
		end else if (block_len_q > CFG_W'(MAX_BLOCK)) begin
			bl = CFG_W'(MAX_BLOCK);
		end else begin
			bl = block_len_q;
		end
		lim = (src_count_q < bl) ? src_count_q : bl;
		for (int j = 0; j < MAX_BLOCK; j++) begin
			src_mask[j] = (CFG_W'(j) < lim);
		end
	end

	assign div_t     = {rem_q, seq_sh_q[SEQ_W-1]};
	assign base      = seq_q - {{(SEQ_W-CFG_W){1'b0}}, rem_q};
	assign end_idx   = (ring_start_q == '0) ? IW'(RING_DEPTH - 1) : ring_start_q - 1'b1;
	assign start_nxt = (ring_start_q == IW'(RING_DEPTH - 1)) ? '0 : ring_start_q + 1'b1;
	assign p_sum     = {1'b0, end_idx} + (IW+1)'(RING_DEPTH) - {1'b0, k_q};
	assign p_idx     = (end_idx >= k_q) ? end_idx - k_q : p_sum[IW-1:0];
	assign scan_i    = NW'(RING_DEPTH) - left_q;
	assign scan_sum  = {1'b0, end_idx} + (IW+1)'(RING_DEPTH) - {1'b0, scan_i[IW-1:0]};
	assign scan_addr = (end_idx >= scan_i[IW-1:0]) ? end_idx - scan_i[IW-1:0]
		: scan_sum[IW-1:0];
	assign far_sum   = {1'b0, base} + {{(SEQ_W-CFG_W){1'b0}}, bl, 1'b0};
	assign off_bit   = MAX_BLOCK'(1) << rem_q[$clog2(MAX_BLOCK)-1:0];
	assign is_cand   = (type_q == CANDIDATE_TYPE);
	assign hit       = v_s1 && ({{(COUNT_W-CFG_W){1'b0}}, src_count_q} <= rec_rd_q.count)
		&& (|(rec_rd_q.recv & rec_rd_q.mark & src_mask));

	always_comb begin
		placed = rec_rd_q;
		placed.recv = rec_rd_q.recv | off_bit;
		placed.mark = is_cand ? (rec_rd_q.mark | off_bit) : (rec_rd_q.mark & ~off_bit);
		if (rec_rd_q.count != {COUNT_W{1'b1}}) begin
			placed.count = rec_rd_q.count + 1'b1;
		end
	end

	always_comb begin
		base_we    = 1'b0;
		base_waddr = clr_idx_q;
		base_wdata = '0;
		base_raddr = (state_q == S_IDLE) ? end_idx : ring_start_q;
		rec_we     = 1'b0;
		rec_waddr  = clr_idx_q;
		rec_wdata  = '0;
		rec_raddr  = (state_q == S_SCAN) ? scan_addr : p_idx;
		case (state_q)
			S_INIT: begin
				base_we = 1'b1;
				rec_we  = 1'b1;
			end
			S_CLR: begin
				base_we = 1'b1;
			end
			S_DEC: begin
				if (base > base_end_q) begin
					base_we    = 1'b1;
					base_waddr = ring_start_q;
					base_wdata = base;
					rec_we     = 1'b1;
					rec_waddr  = ring_start_q;
					rec_wdata.recv  = off_bit;
					rec_wdata.mark  = is_cand ? off_bit : '0;
					rec_wdata.count = COUNT_W'(1);
				end
			end
			S_PLACE: begin
				rec_we    = 1'b1;
				rec_waddr = slot_q;
				rec_wdata = placed;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (base_we) begin
			base_mem[base_waddr] <= base_wdata;
		end
		base_rd_q <= base_mem[base_raddr];
	end

	always_ff @(posedge clk) begin
		if (rec_we) begin
			rec_mem[rec_waddr] <= rec_wdata;
		end
		rec_rd_q <= rec_mem[rec_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_len_q <= BLOCK_LEN_RESET;
			src_count_q <= SRC_COUNT_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_BLOCK_LEN: block_len_q <= cfg_data;
				REG_SRC_COUNT: src_count_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				seq_q    <= seq_num;
				seq_sh_q <= seq_num;
				type_q   <= type_nibble;
				rem_q    <= '0;
			end
			S_DIV: begin
				seq_sh_q <= {seq_sh_q[SEQ_W-2:0], 1'b0};
				rem_q    <= (div_t >= {1'b0, bl}) ? CFG_W'(div_t - {1'b0, bl})
					: div_t[CFG_W-1:0];
				if (div_cnt_q == 5'd0) begin
					base_end_q <= base_rd_q;
				end
				if (div_cnt_q == 5'd1) begin
					base_start_q <= base_rd_q;
				end
			end
			S_DEC: begin
				diff_q <= base_end_q - base;
			end
			S_BACK: begin
				diff_q <= diff_q - {{(SEQ_W-CFG_W){1'b0}}, bl};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			ring_start_q <= '0;
			clr_idx_q    <= '0;
			div_cnt_q    <= '0;
			k_q          <= '0;
			slot_q       <= '0;
			action_q     <= ACT_NEW;
			left_q       <= '0;
			num_s1       <= '0;
			found_q      <= '0;
			second_q     <= '0;
			v_s1         <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			v_s1   <= (state_q == S_SCAN) && (left_q != '0);
			num_s1 <= left_q;
			case (state_q)
				S_INIT, S_CLR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == IW'(RING_DEPTH - 1)) begin
						clr_idx_q <= '0;
						left_q    <= NW'(RING_DEPTH);
						state_q   <= (state_q == S_INIT) ? S_IDLE : S_SCAN;
					end
				end
				S_IDLE: begin
					if (start) begin
						div_cnt_q <= '0;
						found_q   <= '0;
						second_q  <= '0;
						state_q   <= S_DIV;
					end
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == 5'd31) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					slot_q <= '0;
					left_q <= NW'(RING_DEPTH);
					k_q    <= '0;
					if (base > base_end_q) begin
						action_q     <= ACT_NEW;
						slot_q       <= ring_start_q;
						ring_start_q <= start_nxt;
						state_q      <= S_SCAN;
					end else if (base < base_start_q) begin
						if (far_sum <= {1'b0, base_start_q}) begin
							action_q     <= ACT_RESET;
							ring_start_q <= '0;
							state_q      <= S_CLR;
						end else begin
							action_q <= ACT_OLD;
							state_q  <= S_SCAN;
						end
					end else begin
						state_q <= S_BACK;
					end
				end
				S_BACK: begin
					if (diff_q >= {{(SEQ_W-CFG_W){1'b0}}, bl}) begin
						if (k_q == IW'(RING_DEPTH - 1)) begin
							action_q <= ACT_OUT;
							state_q  <= S_SCAN;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end else begin
						slot_q  <= p_idx;
						state_q <= S_PLACE;
					end
				end
				S_PLACE: begin
					action_q <= ACT_PLACE;
					state_q  <= S_SCAN;
				end
				S_SCAN: begin
					if (left_q != '0) begin
						left_q <= left_q - 1'b1;
					end
					if (hit) begin
						if (found_q == '0) begin
							found_q <= num_s1;
						end else if (second_q == '0) begin
							second_q <= num_s1;
						end
					end
					if (left_q == '0 && v_s1) begin
						done_q  <= 1'b1;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign slot_ext     = {{SLOT_W{1'b0}}, slot_q};
	assign ready_ext    = {{READY_W{1'b0}}, (second_q != '0) ? second_q : found_q};
	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign action       = action_q;
	assign ring_slot    = slot_ext[SLOT_W-1:0];
	assign block_offset = rem_q[OFF_W-1:0];
	assign ready_window = ready_ext[READY_W-1:0];
	assign drop_act     = (action == ACT_OLD) || (action == ACT_RESET) || (action == ACT_OUT);

	`FBWT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	`FBWT_ASSERT_NEXT(a_done_single, done, !done)
	`FBWT_ASSERT_IMPLY(a_drop_slot_zero, done && drop_act, ring_slot == '0)
	`FBWT_ASSERT_IMPLY(a_offset_range, done, {1'b0, block_offset} < bl)
endmodule
